// File: sv/avr_pkg.sv
package avr_pkg;

    localparam int MODE_W   = 2;
    localparam int CONT_W   = 3;
    localparam int VOLT_W   = 24;
    localparam int ITER_W   = 10;
    localparam int STEP_W   = 23;
    localparam int CNTU_W   = 4;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 23;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;
    localparam int PROD_W   = 40;

    localparam logic [MODE_W-1:0] MODE_TICK        = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET_WANTED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET_PRESENT = 2'd2;

    localparam logic [CFG_A_W-1:0] CFG_CONTACTS   = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_FAST_BELOW = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_SLOW_ABOVE = 2'd2;
    localparam logic [CFG_A_W-1:0] CFG_MIN_STEP   = 2'd3;

    localparam logic [STEP_W-1:0] STEP_MAX   = 23'h7FFFFF;
    localparam logic [STEP_W-1:0] STEP_RESET = 23'd6554;
    localparam logic [16:0]       GROW_Q16   = 17'd65864;
    localparam logic [16:0]       SHRINK_Q16 = 17'd65470;
    localparam logic [PROD_W:0]   ROUND_HALF = 41'd32768;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_GROW_MUL,
        S_GROW_RND,
        S_SHRINK_MUL,
        S_SHRINK_RND,
        S_FLOOR,
        S_MOVE,
        S_EMIT
    } avr_state_t;

    typedef struct packed {
        logic accept;
        logic idx_clr;
        logic idx_inc;
        logic mul_en;
        logic mul_shrink;
        logic rnd_en;
        logic rnd_sat;
        logic floor_en;
        logic move_en;
        logic load_out;
    } avr_cmd_t;

    typedef struct packed {
        logic in_tick;
        logic idx_end;
        logic off_target;
        logic grow_en;
        logic shrink_en;
        logic out_free;
    } avr_sts_t;

endpackage

// File: sv/adaptive_voltage_ramp.sv
// Channel  Ports      Beat fields (lowest bit up)
// -------  ---------  ----------------------------------------------------------
// input    s_t*       tuser: mode; tdata: contact, value, iterations
// result   m_t*       tdata: contact_index, voltage_now, reached, any_changed,
//                     step_now; tlast: last
// config   cfg_*      cfg_addr selects contacts_in_use, fast_below, slow_above,
//                     min_step
//
// A set beat is taken in the idle state. A tick walks the contacts in use:
// one on target is only stepped past; one off target has its step adapted
// (grow and/or shrink, their products made in one shared multiplier and then
// rounded, then the floor) and moves. The N result beats are then handed out.
// Reset (aresetn low, synchronous) zeroes all voltages and restores the step
// and the registers. A stalled result beat holds the walk in its emit phase;
// no input is taken until the last result beat has been loaded.
module adaptive_voltage_ramp
    import avr_pkg::*;
#(
    parameter int MAX_CONTACTS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // contact, value, iterations
    input  logic [MODE_W-1:0]   s_tuser,   // mode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // contact_index, voltage_now, reached,
                                           // any_changed, step_now
    output logic                m_tlast,
    input  logic                cfg_we,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [CFG_D_W-1:0]  cfg_wdata
);

    avr_cmd_t cmd;
    avr_sts_t sts;

    avr_control u_control (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    avr_datapath #(
        .MAX_CONTACTS (MAX_CONTACTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: sv/avr_datapath.sv
module avr_datapath
    import avr_pkg::*;
#(
    parameter int MAX_CONTACTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [MODE_W-1:0]     s_tuser,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_A_W-1:0]    cfg_addr,
    input  logic [CFG_D_W-1:0]    cfg_wdata,
    input  avr_cmd_t              cmd,
    output avr_sts_t              sts,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,
    output logic                  m_tlast
);

    localparam int CNT_W = $clog2(MAX_CONTACTS + 1);
    localparam int IDX_W = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;

    logic signed [VOLT_W-1:0] present_reg [MAX_CONTACTS];
    logic signed [VOLT_W-1:0] wanted_reg  [MAX_CONTACTS];
    logic [STEP_W-1:0]        step_reg;
    logic [CNTU_W-1:0]        cnt_cfg_reg;
    logic [ITER_W-1:0]        fast_reg;
    logic [ITER_W-1:0]        slow_reg;
    logic [STEP_W-1:0]        min_step_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     changed_reg;

    logic                     m_valid_reg;
    logic [CONT_W-1:0]        o_cidx_reg;
    logic [VOLT_W-1:0]        o_volt_reg;
    logic                     o_reached_reg;
    logic                     o_changed_reg;
    logic [STEP_W-1:0]        o_step_reg;
    logic                     o_last_reg;

    logic [MODE_W-1:0]        in_mode;
    logic [CONT_W-1:0]        in_contact;
    logic [VOLT_W-1:0]        in_value;
    logic [ITER_W-1:0]        in_iter;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         wr_idx;
    logic                     wr_ok;
    logic [CNT_W-1:0]         n_eff;
    logic signed [VOLT_W-1:0] p_cur;
    logic signed [VOLT_W-1:0] w_cur;
    logic signed [VOLT_W+1:0] p_ext;
    logic signed [VOLT_W+1:0] w_ext;
    logic signed [VOLT_W+1:0] sum_up;
    logic signed [VOLT_W+1:0] sum_dn;
    logic signed [VOLT_W-1:0] p_next;
    logic [PROD_W:0]          rnd_full;
    logic [STEP_W+1:0]        rnd_val;
    logic [STEP_W-1:0]        rnd_step;
    logic [16:0]              mul_k;

    assign in_mode    = s_tuser;
    assign in_contact = s_tdata[2:0];
    assign in_value   = s_tdata[26:3];
    assign in_iter    = s_tdata[36:27];

    assign rd_idx = idx_reg[IDX_W-1:0];
    assign wr_idx = IDX_W'(in_contact);
    assign wr_ok  = int'(in_contact) < MAX_CONTACTS;

    always_comb begin
        if (int'(cnt_cfg_reg) > MAX_CONTACTS) begin
            n_eff = CNT_W'(MAX_CONTACTS);
        end else begin
            n_eff = CNT_W'(cnt_cfg_reg);
        end
    end

    assign p_cur  = present_reg[rd_idx];
    assign w_cur  = wanted_reg[rd_idx];
    assign p_ext  = {{2{p_cur[VOLT_W-1]}}, p_cur};
    assign w_ext  = {{2{w_cur[VOLT_W-1]}}, w_cur};
    assign sum_up = p_ext + $signed({3'b000, step_reg});
    assign sum_dn = p_ext - $signed({3'b000, step_reg});

    // Move one step toward the target and stop exactly on it.
    always_comb begin
        if (w_cur > p_cur) begin
            p_next = (sum_up >= w_ext) ? w_cur : sum_up[VOLT_W-1:0];
        end else begin
            p_next = (sum_dn <= w_ext) ? w_cur : sum_dn[VOLT_W-1:0];
        end
    end

    assign mul_k    = cmd.mul_shrink ? SHRINK_Q16 : GROW_Q16;
    assign rnd_full = {1'b0, prod_reg} + ROUND_HALF;
    assign rnd_val  = rnd_full[PROD_W:16];

    always_comb begin
        if (cmd.rnd_sat && (rnd_val > {2'b00, STEP_MAX})) begin
            rnd_step = STEP_MAX;
        end else begin
            rnd_step = rnd_val[STEP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CONTACTS; i++) begin
                present_reg[i] <= '0;
                wanted_reg[i]  <= '0;
            end
        end else if (cmd.accept && wr_ok && (in_mode == MODE_SET_WANTED)) begin
            wanted_reg[wr_idx] <= in_value;
        end else if (cmd.accept && wr_ok && (in_mode == MODE_SET_PRESENT)) begin
            present_reg[wr_idx] <= in_value;
        end else if (cmd.move_en) begin
            present_reg[rd_idx] <= p_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_cfg_reg  <= CNTU_W'(2);
            fast_reg     <= ITER_W'(16);
            slow_reg     <= ITER_W'(18);
            min_step_reg <= STEP_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_CONTACTS:   cnt_cfg_reg  <= cfg_wdata[CNTU_W-1:0];
                CFG_FAST_BELOW: fast_reg     <= cfg_wdata[ITER_W-1:0];
                CFG_SLOW_ABOVE: slow_reg     <= cfg_wdata[ITER_W-1:0];
                CFG_MIN_STEP:   min_step_reg <= cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_RESET;
            idx_reg     <= '0;
            changed_reg <= 1'b0;
        end else begin
            if (cmd.rnd_en) begin
                step_reg <= rnd_step;
            end else if (cmd.floor_en && (step_reg < min_step_reg)) begin
                step_reg <= min_step_reg;
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (cmd.accept && sts.in_tick) begin
                changed_reg <= 1'b0;
            end else if (cmd.move_en) begin
                changed_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && sts.in_tick) begin
            iter_reg <= in_iter;
        end
        if (cmd.mul_en) begin
            prod_reg <= {{(PROD_W-STEP_W){1'b0}}, step_reg} * {{(PROD_W-17){1'b0}}, mul_k};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            o_cidx_reg    <= CONT_W'(idx_reg);
            o_volt_reg    <= p_cur;
            o_reached_reg <= (p_cur == w_cur);
            o_changed_reg <= changed_reg;
            o_step_reg    <= step_reg;
            o_last_reg    <= ((idx_reg + CNT_W'(1)) == n_eff);
        end
    end

    assign sts.in_tick    = (in_mode == MODE_TICK);
    assign sts.idx_end    = (idx_reg >= n_eff);
    assign sts.off_target = (p_cur != w_cur);
    assign sts.grow_en    = (iter_reg < fast_reg);
    assign sts.shrink_en  = (iter_reg > slow_reg);
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {4'b0000, o_step_reg, o_changed_reg, o_reached_reg,
                       o_volt_reg, o_cidx_reg};

    // The walk counter never runs beyond one past the last store entry.
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(idx_reg) <= MAX_CONTACTS)
        else $error("walk index beyond contact store");

endmodule

// File: sv/avr_control.sv
module avr_control
    import avr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  avr_sts_t sts,
    output avr_cmd_t cmd
);

    avr_state_t state_reg;
    avr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.in_tick) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (sts.idx_end) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_EMIT;
                end else if (!sts.off_target) begin
                    cmd.idx_inc = 1'b1;
                end else if (sts.grow_en) begin
                    state_next = S_GROW_MUL;
                end else if (sts.shrink_en) begin
                    state_next = S_SHRINK_MUL;
                end else begin
                    state_next = S_FLOOR;
                end
            end
            S_GROW_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_GROW_RND;
            end
            S_GROW_RND: begin
                cmd.rnd_en  = 1'b1;
                cmd.rnd_sat = 1'b1;
                state_next  = sts.shrink_en ? S_SHRINK_MUL : S_FLOOR;
            end
            S_SHRINK_MUL: begin
                cmd.mul_en     = 1'b1;
                cmd.mul_shrink = 1'b1;
                state_next     = S_SHRINK_RND;
            end
            S_SHRINK_RND: begin
                cmd.rnd_en = 1'b1;
                state_next = S_FLOOR;
            end
            S_FLOOR: begin
                cmd.floor_en = 1'b1;
                state_next   = S_MOVE;
            end
            S_MOVE: begin
                cmd.move_en = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_CHECK;
            end
            S_EMIT: begin
                if (sts.idx_end) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.idx_inc  = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // A result beat is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result register overwritten");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == S_IDLE))
        else $error("input taken while busy");

    a_tick_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && sts.in_tick) |=> (state_reg == S_CHECK))
        else $error("tick did not start the walk");

    a_move_after_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.move_en |-> $past(cmd.floor_en))
        else $error("move without step floor");

endmodule

// File: sim/adaptive_voltage_ramp_test.sv
module adaptive_voltage_ramp_test;
    import avr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CONTACTS = 8;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // Settling time for the longest tick: all 8 contacts off target, plus hand-out.
    localparam int SETTLE_CYCLES = 100;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CONT_W-1:0] contact;
        logic [VOLT_W-1:0] value;
        logic [ITER_W-1:0] iters;
    } ramp_beat_t;

    typedef struct packed {
        logic [CONT_W-1:0] idx;
        logic [VOLT_W-1:0] volt;
        logic              reached;
        logic              moved;
        logic [STEP_W-1:0] step;
        logic              last;
    } ramp_report_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_we = 1'b0;
    logic [CFG_A_W-1:0]  cfg_addr = '0;
    logic [CFG_D_W-1:0]  cfg_wdata = '0;

    adaptive_voltage_ramp #(
        .MAX_CONTACTS(MAX_CONTACTS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Shadow copy of the ramp state and registers.
    logic signed [VOLT_W-1:0] volt_now  [MAX_CONTACTS];
    logic signed [VOLT_W-1:0] volt_goal [MAX_CONTACTS];
    logic [STEP_W-1:0]        ramp_step = STEP_RESET;
    logic [CNTU_W-1:0]        cfg_contacts = 4'd2;
    logic [ITER_W-1:0]        cfg_fast = 10'd16;
    logic [ITER_W-1:0]        cfg_slow = 10'd18;
    logic [STEP_W-1:0]        cfg_min_step = STEP_RESET;

    ramp_beat_t   pending_beats[$];
    ramp_report_t expected_reports[$];
    int           beats_queued = 0;
    int           beats_taken = 0;
    int           bad_beats = 0;

    initial begin
        for (int i = 0; i < MAX_CONTACTS; i++) begin
            volt_now[i] = '0;
            volt_goal[i] = '0;
        end
    end

    task automatic ramp_tick(input logic [ITER_W-1:0] iters);
        int n;
        logic moved;
        logic [PROD_W:0] prod;
        logic [24:0] s;
        logic signed [25:0] p;
        logic signed [25:0] w;
        logic signed [25:0] stp;
        ramp_report_t r;
        n = (cfg_contacts > MAX_CONTACTS) ? MAX_CONTACTS : int'(cfg_contacts);
        moved = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (volt_now[i] != volt_goal[i]) begin
                moved = 1'b1;
                s = {2'b00, ramp_step};
                if (iters < cfg_fast) begin
                    prod = s * GROW_Q16 + ROUND_HALF;
                    s = prod[40:16];
                    if (s > STEP_MAX) s = {2'b00, STEP_MAX};
                end
                if (iters > cfg_slow) begin
                    prod = s * SHRINK_Q16 + ROUND_HALF;
                    s = prod[40:16];
                end
                if (s < cfg_min_step) s = {2'b00, cfg_min_step};
                ramp_step = s[STEP_W-1:0];
                p = volt_now[i];
                w = volt_goal[i];
                stp = $signed({3'b000, ramp_step});
                if (w > p) begin
                    p = (p + stp >= w) ? w : p + stp;
                end else begin
                    p = (p - stp <= w) ? w : p - stp;
                end
                volt_now[i] = p[VOLT_W-1:0];
            end
        end
        for (int i = 0; i < n; i++) begin
            r.idx = i[CONT_W-1:0];
            r.volt = volt_now[i];
            r.reached = (volt_now[i] == volt_goal[i]);
            r.moved = moved;
            r.step = ramp_step;
            r.last = (i + 1 == n);
            expected_reports.push_back(r);
        end
    endtask

    task automatic apply_beat(input ramp_beat_t b);
        case (b.mode)
            MODE_SET_WANTED:  volt_goal[b.contact] = b.value;
            MODE_SET_PRESENT: volt_now[b.contact] = b.value;
            MODE_TICK:        ramp_tick(b.iters);
            default: ;
        endcase
    endtask

    // Driver: bursts of beats separated by random gaps.
    ramp_beat_t held_beat;
    int burst_left = 4;
    int gap_left = 0;

    always @(posedge aclk) begin
        logic fire;
        logic next_valid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            fire = s_tvalid && s_tready;
            next_valid = s_tvalid;
            if (fire) begin
                apply_beat(held_beat);
                beats_taken++;
            end
            if (!s_tvalid || fire) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_beats.size() > 0) begin
                    held_beat = pending_beats.pop_front();
                    s_tdata <= {3'b000, held_beat.iters, held_beat.value, held_beat.contact};
                    s_tuser <= held_beat.mode;
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: the stall pattern is picked at random from four styles.
    int cycle_count = 0;
    int ready_style = 0;
    int stall_left = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count % 256 == 0) ready_style = $urandom_range(0, 3);
        case (ready_style)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (cycle_count % 4 == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(5, 30);
                end
            end
        endcase
    end

    // Monitor: every result beat is checked against the oldest expectation.
    always @(posedge aclk) begin
        ramp_report_t got;
        ramp_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.idx = m_tdata[2:0];
            got.volt = m_tdata[26:3];
            got.reached = m_tdata[27];
            got.moved = m_tdata[28];
            got.step = m_tdata[51:29];
            got.last = m_tlast;
            if (expected_reports.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10)
                    $display("unexpected result beat: idx=%0d volt=%h step=%h last=%b",
                             got.idx, got.volt, got.step, got.last);
            end else begin
                want = expected_reports.pop_front();
                if (got != want) begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display({"result mismatch: expected idx=%0d volt=%h reached=%b ",
                                  "moved=%b step=%h last=%b, got idx=%0d volt=%h reached=%b ",
                                  "moved=%b step=%h last=%b"},
                                 want.idx, want.volt, want.reached, want.moved, want.step,
                                 want.last, got.idx, got.volt, got.reached, got.moved,
                                 got.step, got.last);
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on either channel.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic queue_beat(input logic [MODE_W-1:0] mode, input logic [CONT_W-1:0] contact,
                              input logic [VOLT_W-1:0] value, input logic [ITER_W-1:0] iters);
        ramp_beat_t b;
        b.mode = mode;
        b.contact = contact;
        b.value = value;
        b.iters = iters;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (beats_taken != beats_queued || expected_reports.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_D_W-1:0] data);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        case (addr)
            CFG_CONTACTS:   cfg_contacts = data[CNTU_W-1:0];
            CFG_FAST_BELOW: cfg_fast = data[ITER_W-1:0];
            CFG_SLOW_ABOVE: cfg_slow = data[ITER_W-1:0];
            CFG_MIN_STEP:   cfg_min_step = data[STEP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [VOLT_W-1:0] pick_volt();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return VOLT_W'($urandom_range(0, 200000));
            3: return VOLT_W'(-$urandom_range(0, 200000));
            default: return VOLT_W'($urandom);
        endcase
    endfunction

    function automatic logic [ITER_W-1:0] pick_iters();
        case ($urandom_range(0, 7))
            0: return cfg_fast - 1'b1;
            1: return cfg_fast;
            2: return cfg_slow;
            3: return cfg_slow + 1'b1;
            default: return ITER_W'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int count);
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 65)
                queue_beat(MODE_TICK, CONT_W'($urandom), VOLT_W'($urandom), pick_iters());
            else if (r < 80)
                queue_beat(MODE_SET_WANTED, CONT_W'($urandom), pick_volt(), ITER_W'($urandom));
            else if (r < 95)
                queue_beat(MODE_SET_PRESENT, CONT_W'($urandom), pick_volt(), ITER_W'($urandom));
            else
                queue_beat(MODE_UNUSED, CONT_W'($urandom), VOLT_W'($urandom),
                           ITER_W'($urandom));
        end
    endtask

    // One setting of the registers: drain, let the walk finish, reprogram,
    // load targets, then random traffic with a full drain halfway through.
    task automatic run_phase(input logic [CNTU_W-1:0] contacts, input logic [ITER_W-1:0] fast,
                             input logic [ITER_W-1:0] slow, input logic [STEP_W-1:0] floor_step,
                             input int count);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(CFG_CONTACTS, CFG_D_W'(contacts));
        write_reg(CFG_FAST_BELOW, CFG_D_W'(fast));
        write_reg(CFG_SLOW_ABOVE, CFG_D_W'(slow));
        write_reg(CFG_MIN_STEP, floor_step);
        for (int c = 0; c < MAX_CONTACTS; c++)
            queue_beat(MODE_SET_WANTED, CONT_W'(c), pick_volt(), ITER_W'($urandom));
        queue_random(count / 2);
        wait_drained();
        queue_random(count - count / 2);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset settings.
        queue_beat(MODE_TICK, 3'd5, 24'h0, 10'd0);
        queue_beat(MODE_SET_WANTED, 3'd0, 24'h7FFFFF, 10'd0);
        queue_beat(MODE_SET_PRESENT, 3'd0, 24'h800000, 10'd1023);
        queue_beat(MODE_SET_WANTED, 3'd1, 24'h800000, 10'd0);
        queue_beat(MODE_TICK, 3'd7, 24'hFFFFFF, 10'd0);
        queue_beat(MODE_TICK, 3'd0, 24'h0, 10'd1023);
        queue_beat(MODE_TICK, 3'd0, 24'h0, 10'd15);
        queue_beat(MODE_TICK, 3'd0, 24'h0, 10'd16);
        queue_beat(MODE_TICK, 3'd0, 24'h0, 10'd17);
        queue_beat(MODE_TICK, 3'd0, 24'h0, 10'd18);
        queue_beat(MODE_TICK, 3'd0, 24'h0, 10'd19);
        queue_beat(MODE_UNUSED, 3'd1, 24'h123456, 10'd0);
        queue_beat(MODE_UNUSED, 3'd6, 24'hA5A5A5, 10'h3FF);
        queue_beat(MODE_SET_WANTED, 3'd7, 24'h000123, 10'd0);
        queue_beat(MODE_SET_PRESENT, 3'd7, 24'hFFFF00, 10'd0);
        // Present just above the target: the step overshoots and clamps.
        queue_beat(MODE_SET_PRESENT, 3'd1, 24'h800064, 10'd0);
        queue_beat(MODE_TICK, 3'd0, 24'h0, 10'd0);
        queue_beat(MODE_SET_WANTED, 3'd0, 24'h000000, 10'd0);
        queue_beat(MODE_SET_PRESENT, 3'd0, 24'h000000, 10'd0);
        queue_beat(MODE_TICK, 3'd0, 24'h0, 10'd512);

        // All contacts, growing below 1023 iterations, never shrinking, tiny floor.
        run_phase(4'd8, 10'd1023, 10'd1023, 23'd1, 50);
        // No contacts walked: ticks give no results.
        run_phase(4'd0, ITER_W'($urandom), ITER_W'($urandom), STEP_W'($urandom), 16);
        // Count above the contact total, never growing, shrinking above zero iterations, largest floor.
        run_phase(4'd15, 10'd0, 10'd0, 23'h7FFFFF, 40);
        // Grow and shrink both apply between the thresholds, no floor.
        run_phase(4'd1, 10'd512, 10'd256, 23'd0, 50);
        run_phase(CNTU_W'($urandom_range(1, 8)), ITER_W'($urandom), ITER_W'($urandom),
                  STEP_W'($urandom_range(1, 20000)), 50);
        run_phase(CNTU_W'($urandom), ITER_W'($urandom), ITER_W'($urandom),
                  STEP_W'($urandom), 50);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (bad_beats == 0 && expected_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: adaptive_voltage_ramp.f
sv/avr_pkg.sv
sv/avr_datapath.sv
sv/avr_control.sv
sv/adaptive_voltage_ramp.sv
sim/adaptive_voltage_ramp_test.sv
